@@ src/dla_pkg.sv @@
`default_nettype none

package dla_pkg;

	// Request opcodes.
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_SWEEP   = 2'd2;
	localparam logic [1:0] OP_RESERVE = 2'd3;

	// Response status codes.
	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_NO_ADDRESS    = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND     = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL    = 3'd3;
	localparam logic [2:0] ST_NOT_IN_SUBNET = 3'd4;

	// Configuration register indexes.
	localparam logic REG_SUBNET_BASE = 1'b0;
	localparam logic REG_PREFIX_LEN  = 1'b1;

	localparam logic [19:0] US_PER_SEC   = 20'd1000000;
	localparam logic [31:0] ADDR_MASK    = 32'hFFFFFFFF;
	localparam logic [8:0]  COUNT_MAX    = 9'd511;
	localparam logic [4:0]  PREFIX_RESET = 5'd24;

	// One word of the host map: the three flags kept per host index.
	typedef struct packed {
		logic free;
		logic released;
		logic reserved;
	} map_bits_t;

endpackage

`default_nettype wire

@@ src/dhcp_lease_allocator.sv @@
// Requests are taken one at a time: reserve, sweep, release and allocate each run to
// completion before the next request is accepted. Reset and every register write start a
// clearing pass over the host map; the response waits in an output register while a new
// request may enter.
`default_nettype none

module dhcp_lease_allocator #(
	parameter int HOST_BITS     = 10,
	parameter int LEASE_ENTRIES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	// Request channel.
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  op,
	input  wire logic [47:0] mac,
	input  wire logic [31:0] lease_seconds,
	input  wire logic [63:0] now_us,
	input  wire logic [31:0] reserve_ip,
	// Response channel.
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [2:0]       status,
	output logic [31:0]      ip_addr,
	output logic [8:0]       expired_count,
	output logic [8:0]       removed_count
);

	import dla_pkg::*;

	localparam int EW       = $clog2(LEASE_ENTRIES);
	localparam int HB       = HOST_BITS;
	localparam int MAP_SIZE = 1 << HOST_BITS;

	localparam logic [EW:0] N_ENT    = (EW + 1)'(LEASE_ENTRIES);
	localparam logic [HB:0] MAP_LAST = (HB + 1)'(MAP_SIZE - 1);

	// One lease table word. The released flag travels with the rest of the word, so
	// every update of a lease is a read-modify-write of one entry.
	typedef struct packed {
		logic [47:0]   mac;
		logic [HB-1:0] index;
		logic [63:0]   expiry;
		logic          released;
	} entry_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_ADD,
		S_FIND_RD,
		S_FIND_CMP,
		S_OWN_RD,
		S_OWN_CHK,
		S_POOL_RD,
		S_POOL_CHK,
		S_POOL_END,
		S_NEW_RD,
		S_NEW_WR,
		S_SWP_RD,
		S_SWP_ENT,
		S_SWP_MRD,
		S_SWP_CHK,
		S_RSV,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [31:0] base_q;
	logic [4:0]  prefix_q;

	// The captured request.
	logic [1:0]  op_q;
	logic [47:0] mac_q;
	logic [31:0] secs_q;
	logic [63:0] now_q;
	logic [31:0] rip_q;

	// Working registers of the sequencer.
	logic [51:0]   prod_q;
	logic [63:0]   expiry_q;
	logic [EW:0]   e_q;
	logic [HB:0]   m_q;
	logic [HB-1:0] idx_q;
	logic [EW-1:0] slot_q;
	logic          slot_found_q;
	logic [HB-1:0] free_idx_q;
	logic          have_free_q;
	logic [HB-1:0] rel_idx_q;
	logic          have_rel_q;
	logic [2:0]    st_q;
	logic [31:0]   ip_q;
	logic [8:0]    exp_q;
	logic [8:0]    rem_q;

	logic [LEASE_ENTRIES-1:0] valid_q;

	// Response register.
	logic        rsp_valid_q;
	logic [2:0]  rsp_status_q;
	logic [31:0] rsp_ip_q;
	logic [8:0]  rsp_exp_q;
	logic [8:0]  rsp_rem_q;

	// Memories: the lease table and the host map, each with a registered read.
	entry_t    ent_mem [LEASE_ENTRIES];
	map_bits_t map_mem [MAP_SIZE];
	entry_t    ent_rd_q;
	map_bits_t map_rd_q;

	logic          ent_we;
	logic [EW-1:0] ent_wa;
	entry_t        ent_wd;
	logic          map_we;
	logic [HB-1:0] map_wa;
	map_bits_t     map_wd;
	logic [HB-1:0] map_ra;

	// Pool geometry from the prefix length: host bits clamped to [2, HOST_BITS].
	logic [5:0]    hb_raw;
	logic [5:0]    hb;
	logic [HB:0]   pool;
	logic [31:0]   hmask;
	logic [HB-1:0] rsv_idx;
	logic          rsv_in_subnet;
	logic          renew_ok;
	logic          stale;
	logic          clr_free;
	logic [HB-1:0] cand_idx;
	logic [31:0]   new_ip;

	assign hb_raw = 6'd32 - {1'b0, prefix_q};

	always_comb begin
		hb = hb_raw;
		if (hb_raw > 6'(HOST_BITS)) begin
			hb = 6'(HOST_BITS);
		end
		if (hb_raw < 6'd2) begin
			hb = 6'd2;
		end
	end

	assign pool          = (HB + 1)'(1) << hb;
	assign hmask         = ~(ADDR_MASK << hb);
	assign rsv_idx       = rip_q[HB-1:0] & hmask[HB-1:0];
	assign rsv_in_subnet = (rip_q & ~hmask) == (base_q & ~hmask);
	assign renew_ok      = !map_rd_q.reserved && (!ent_rd_q.released || map_rd_q.released);
	assign stale         = ent_rd_q.released && !map_rd_q.released;
	assign clr_free      = (m_q != '0) && (m_q < pool - (HB + 1)'(1));
	assign cand_idx      = have_free_q ? free_idx_q : rel_idx_q;
	assign new_ip        = base_q + {{(32 - HB){1'b0}}, cand_idx};

	assign map_ra = (state_q == S_POOL_RD || state_q == S_POOL_CHK) ? m_q[HB-1:0] : idx_q;
	assign ent_wa = (state_q == S_NEW_WR) ? slot_q : e_q[EW-1:0];

	// Write data for both memories, built from the word just read where a flag must stay.
	always_comb begin
		ent_we = 1'b0;
		ent_wd = ent_rd_q;
		map_we = 1'b0;
		map_wa = idx_q;
		map_wd = map_rd_q;
		case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				map_wa = m_q[HB-1:0];
				map_wd = '{free: clr_free, released: 1'b0, reserved: 1'b0};
			end
			S_OWN_CHK: begin
				if (op_q == OP_RELEASE) begin
					ent_we          = 1'b1;
					ent_wd.released = 1'b1;
					map_we          = 1'b1;
					map_wd.free     = 1'b0;
					map_wd.released = 1'b1;
				end else if (renew_ok) begin
					ent_we          = 1'b1;
					ent_wd.expiry   = expiry_q;
					ent_wd.released = 1'b0;
					map_we          = 1'b1;
					map_wd.free     = 1'b0;
					map_wd.released = 1'b0;
				end
			end
			S_NEW_WR: begin
				ent_we          = 1'b1;
				ent_wd          = '{mac: mac_q, index: idx_q, expiry: expiry_q, released: 1'b0};
				map_we          = 1'b1;
				map_wd.free     = 1'b0;
				map_wd.released = 1'b0;
			end
			S_SWP_CHK: begin
				if (!stale && (now_q > ent_rd_q.expiry)) begin
					ent_we          = 1'b1;
					ent_wd.released = 1'b1;
					map_we          = 1'b1;
					map_wd.released = 1'b1;
				end
			end
			S_RSV: begin
				if (rsv_in_subnet) begin
					map_we = 1'b1;
					map_wa = rsv_idx;
					map_wd = '{free: 1'b0, released: 1'b0, reserved: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		ent_rd_q <= ent_mem[e_q[EW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[map_ra];
	end

	// Payload registers: loaded without reset.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q   <= op;
			mac_q  <= mac;
			secs_q <= lease_seconds;
			now_q  <= now_us;
			rip_q  <= reserve_ip;
		end
		if (state_q == S_MUL) begin
			prod_q <= secs_q * US_PER_SEC;
		end
		if (state_q == S_ADD) begin
			expiry_q <= now_q + {12'd0, prod_q};
		end
	end

	// The sequencer. It walks the lease table one entry at a time for the MAC search and
	// the sweep, and the host map one index at a time for the first free or released host.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			base_q       <= '0;
			prefix_q     <= PREFIX_RESET;
			valid_q      <= '0;
			e_q          <= '0;
			m_q          <= '0;
			idx_q        <= '0;
			slot_q       <= '0;
			slot_found_q <= 1'b0;
			free_idx_q   <= '0;
			have_free_q  <= 1'b0;
			rel_idx_q    <= '0;
			have_rel_q   <= 1'b0;
			st_q         <= ST_OK;
			ip_q         <= '0;
			exp_q        <= '0;
			rem_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_ip_q     <= '0;
			rsp_exp_q    <= '0;
			rsp_rem_q    <= '0;
		end else begin
			// In the done state the response register is reloaded below instead.
			if (rsp_valid_q && rsp_ready && (cfg_we || state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				// Any write, even of the same value, empties the table and rebuilds the map.
				if (cfg_index == REG_SUBNET_BASE) begin
					base_q <= cfg_wdata;
				end else begin
					prefix_q <= cfg_wdata[4:0];
				end
				valid_q <= '0;
				m_q     <= '0;
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						m_q <= m_q + (HB + 1)'(1);
						if (m_q == MAP_LAST) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (req_valid) begin
							e_q          <= '0;
							slot_found_q <= 1'b0;
							st_q         <= ST_OK;
							ip_q         <= '0;
							exp_q        <= '0;
							rem_q        <= '0;
							case (op)
								OP_ALLOC:   state_q <= S_MUL;
								OP_RELEASE: state_q <= S_FIND_RD;
								OP_SWEEP:   state_q <= S_SWP_RD;
								default:    state_q <= S_RSV;
							endcase
						end
					end
					S_MUL: state_q <= S_ADD;
					S_ADD: state_q <= S_FIND_RD;
					S_FIND_RD: begin
						if (e_q == N_ENT) begin
							if (op_q == OP_RELEASE) begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end else begin
								m_q         <= '0;
								have_free_q <= 1'b0;
								have_rel_q  <= 1'b0;
								state_q     <= S_POOL_RD;
							end
						end else if (!valid_q[e_q[EW-1:0]]) begin
							// The first empty slot seen is where a new lease would go.
							if (!slot_found_q) begin
								slot_q       <= e_q[EW-1:0];
								slot_found_q <= 1'b1;
							end
							e_q <= e_q + (EW + 1)'(1);
						end else begin
							state_q <= S_FIND_CMP;
						end
					end
					S_FIND_CMP: begin
						if (ent_rd_q.mac == mac_q) begin
							idx_q   <= ent_rd_q.index;
							state_q <= S_OWN_RD;
						end else begin
							e_q     <= e_q + (EW + 1)'(1);
							state_q <= S_FIND_RD;
						end
					end
					S_OWN_RD: state_q <= S_OWN_CHK;
					S_OWN_CHK: begin
						if (op_q == OP_RELEASE) begin
							state_q <= S_DONE;
						end else if (renew_ok) begin
							ip_q    <= base_q + {{(32 - HB){1'b0}}, idx_q};
							state_q <= S_DONE;
						end else begin
							// Renewal refused: the lease is dropped and its slot may be reused.
							valid_q[e_q[EW-1:0]] <= 1'b0;
							if (!slot_found_q) begin
								slot_q       <= e_q[EW-1:0];
								slot_found_q <= 1'b1;
							end
							m_q         <= '0;
							have_free_q <= 1'b0;
							have_rel_q  <= 1'b0;
							state_q     <= S_POOL_RD;
						end
					end
					S_POOL_RD: begin
						if (m_q == pool) begin
							state_q <= S_POOL_END;
						end else begin
							state_q <= S_POOL_CHK;
						end
					end
					S_POOL_CHK: begin
						m_q <= m_q + (HB + 1)'(1);
						if (map_rd_q.released && !have_rel_q) begin
							rel_idx_q  <= m_q[HB-1:0];
							have_rel_q <= 1'b1;
						end
						if (map_rd_q.free) begin
							free_idx_q  <= m_q[HB-1:0];
							have_free_q <= 1'b1;
							state_q     <= S_POOL_END;
						end else begin
							state_q <= S_POOL_RD;
						end
					end
					S_POOL_END: begin
						if (!have_free_q && !have_rel_q) begin
							st_q    <= ST_NO_ADDRESS;
							state_q <= S_DONE;
						end else if (!slot_found_q) begin
							st_q    <= ST_TABLE_FULL;
							state_q <= S_DONE;
						end else begin
							// The subnet base's own host bits shift the index that is stored.
							ip_q    <= new_ip;
							idx_q   <= new_ip[HB-1:0] & hmask[HB-1:0];
							state_q <= S_NEW_RD;
						end
					end
					S_NEW_RD: state_q <= S_NEW_WR;
					S_NEW_WR: begin
						valid_q[slot_q] <= 1'b1;
						state_q         <= S_DONE;
					end
					S_SWP_RD: begin
						if (e_q == N_ENT) begin
							state_q <= S_DONE;
						end else if (!valid_q[e_q[EW-1:0]]) begin
							e_q <= e_q + (EW + 1)'(1);
						end else begin
							state_q <= S_SWP_ENT;
						end
					end
					S_SWP_ENT: begin
						idx_q   <= ent_rd_q.index;
						state_q <= S_SWP_MRD;
					end
					S_SWP_MRD: state_q <= S_SWP_CHK;
					S_SWP_CHK: begin
						if (stale) begin
							valid_q[e_q[EW-1:0]] <= 1'b0;
							if (rem_q != COUNT_MAX) begin
								rem_q <= rem_q + 9'd1;
							end
						end else if (now_q > ent_rd_q.expiry) begin
							if (exp_q != COUNT_MAX) begin
								exp_q <= exp_q + 9'd1;
							end
						end
						e_q     <= e_q + (EW + 1)'(1);
						state_q <= S_SWP_RD;
					end
					S_RSV: begin
						if (!rsv_in_subnet) begin
							st_q <= ST_NOT_IN_SUBNET;
						end
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (!rsp_valid_q || rsp_ready) begin
							rsp_valid_q  <= 1'b1;
							rsp_status_q <= st_q;
							rsp_ip_q     <= ip_q;
							rsp_exp_q    <= exp_q;
							rsp_rem_q    <= rem_q;
							state_q      <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign req_ready     = (state_q == S_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign ip_addr       = rsp_ip_q;
	assign expired_count = rsp_exp_q;
	assign removed_count = rsp_rem_q;

	// A register write leaves no lease behind.
	a_cfg_empties_table: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (valid_q == '0))
		else $error("lease table not emptied by a register write");

	// One request at a time: an accepted request closes the input until it is done.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in progress");

	// Only a successful allocate carries an address.
	a_ip_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != ST_OK)) |-> (ip_addr == '0))
		else $error("address returned with a failing status");

	// Counts come only from a sweep, which always reports ok.
	a_counts_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != ST_OK)) |-> ((expired_count == '0) && (removed_count == '0)))
		else $error("sweep counts returned with a failing status");

endmodule

`default_nettype wire

@@ tb/tb_dhcp_lease_allocator.sv @@
`default_nettype none

module tb_dhcp_lease_allocator;
	import dla_pkg::*;

	// Sizes of the block as instantiated with its default parameters.
	localparam int HOST_W   = 10;
	localparam int MAP_N    = 1 << HOST_W;
	localparam int LEASE_N  = 256;
	localparam int N_PHASES = 9;

	// One request as it is driven onto the request channel.
	typedef struct {
		logic [1:0]  op;
		logic [47:0] mac;
		logic [31:0] secs;
		logic [63:0] now;
		logic [31:0] rip;
	} lease_req_t;

	// One response, compared field by field.
	typedef struct {
		logic [2:0]  status;
		logic [31:0] ip;
		logic [8:0]  expired;
		logic [8:0]  removed;
	} lease_rsp_t;

	// A row of the directed table: the request, and a typed response where one is given.
	typedef struct {
		lease_req_t req;
		bit         typed;
		lease_rsp_t rsp;
	} lease_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  op;
	logic [47:0] mac;
	logic [31:0] lease_seconds;
	logic [63:0] now_us;
	logic [31:0] reserve_ip;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [2:0]  status;
	logic [31:0] ip_addr;
	logic [8:0]  expired_count;
	logic [8:0]  removed_count;

	dhcp_lease_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.op            (op),
		.mac           (mac),
		.lease_seconds (lease_seconds),
		.now_us        (now_us),
		.reserve_ip    (reserve_ip),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.ip_addr       (ip_addr),
		.expired_count (expired_count),
		.removed_count (removed_count)
	);

	// Shadow copy of the registers and of every store of the block.
	logic [31:0] pool_base;
	logic [4:0]  pool_prefix;
	bit          lease_valid [LEASE_N];
	logic [47:0] lease_mac   [LEASE_N];
	logic [31:0] lease_idx   [LEASE_N];
	logic [63:0] lease_exp   [LEASE_N];
	bit          lease_rel   [LEASE_N];
	bit          free_host   [MAP_N];
	bit          rel_host    [MAP_N];
	bit          rsvd_host   [MAP_N];

	// Responses still owed by the block, oldest first.
	lease_rsp_t  owed_rsp_q[$];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned mismatches;
	int unsigned rsp_seen;
	int unsigned op_seen  [4];
	int unsigned st_seen  [5];
	logic [63:0] clock_us;
	logic [47:0] mac_pool [8];

	// The clock runs with a period of eight units.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Host bits in use: the prefix turned round and clamped to the range the pool supports.
	function automatic int unsigned pool_host_bits();
		int unsigned hb;
		hb = 32 - pool_prefix;
		if (hb > HOST_W)
			hb = HOST_W;
		if (hb < 2)
			hb = 2;
		return hb;
	endfunction

	function automatic logic [31:0] pool_host_mask();
		return (32'd1 << pool_host_bits()) - 32'd1;
	endfunction

	// Every register write empties the lease table and the reserved and released maps,
	// and puts back the free map with the network and broadcast indices left out.
	function automatic void clear_pool();
		int unsigned pool;
		pool = 1 << pool_host_bits();
		for (int i = 0; i < LEASE_N; i++)
			lease_valid[i] = 1'b0;
		for (int i = 0; i < MAP_N; i++) begin
			rel_host[i]  = 1'b0;
			rsvd_host[i] = 1'b0;
			free_host[i] = (i > 0) && (i < pool - 1);
		end
	endfunction

	function automatic int find_lease(logic [47:0] m);
		for (int i = 0; i < LEASE_N; i++)
			if (lease_valid[i] && lease_mac[i] == m)
				return i;
		return -1;
	endfunction

	// Works out the response to one request and moves the shadow state on.
	function automatic lease_rsp_t predict_lease(lease_req_t r);
		lease_rsp_t  o;
		logic [63:0] expiry;
		logic [31:0] idx;
		logic [31:0] addr;
		int unsigned pool;
		int          e;
		bit          found;
		o = '{ST_OK, 32'd0, 9'd0, 9'd0};
		case (r.op)
			OP_ALLOC: begin
				expiry = r.now + {32'd0, r.secs} * 64'd1000000;
				pool   = 1 << pool_host_bits();
				e      = find_lease(r.mac);
				if (e >= 0) begin
					idx = lease_idx[e] & (MAP_N - 1);
					// The lease is renewed unless its address has since been reserved, or
					// it was released and its address has been handed to someone else.
					if (!rsvd_host[idx] && (!lease_rel[e] || rel_host[idx])) begin
						free_host[idx] = 1'b0;
						rel_host[idx]  = 1'b0;
						lease_exp[e]   = expiry;
						lease_rel[e]   = 1'b0;
						o.ip = pool_base + idx;
						return o;
					end
					lease_valid[e] = 1'b0;
				end
				found = 1'b0;
				idx   = 0;
				for (int i = 0; i < pool && !found; i++)
					if (free_host[i]) begin
						idx   = i;
						found = 1'b1;
					end
				for (int i = 0; i < pool && !found; i++)
					if (rel_host[i]) begin
						idx   = i;
						found = 1'b1;
					end
				if (!found) begin
					o.status = ST_NO_ADDRESS;
					return o;
				end
				e = -1;
				for (int i = LEASE_N - 1; i >= 0; i--)
					if (!lease_valid[i])
						e = i;
				if (e < 0) begin
					o.status = ST_TABLE_FULL;
					return o;
				end
				// The host bits of the address itself become the index, so a base with
				// host bits set moves the lease to another index.
				addr = pool_base + idx;
				idx  = addr & pool_host_mask();
				free_host[idx] = 1'b0;
				rel_host[idx]  = 1'b0;
				lease_valid[e] = 1'b1;
				lease_mac[e]   = r.mac;
				lease_idx[e]   = idx;
				lease_exp[e]   = expiry;
				lease_rel[e]   = 1'b0;
				o.ip = addr;
			end
			OP_RELEASE: begin
				e = find_lease(r.mac);
				if (e < 0) begin
					o.status = ST_NOT_FOUND;
					return o;
				end
				idx = lease_idx[e] & (MAP_N - 1);
				free_host[idx] = 1'b0;
				rel_host[idx]  = 1'b1;
				lease_rel[e]   = 1'b1;
			end
			OP_SWEEP: begin
				for (int i = 0; i < LEASE_N; i++) begin
					if (lease_valid[i]) begin
						idx = lease_idx[i] & (MAP_N - 1);
						if (lease_rel[i] && !rel_host[idx]) begin
							lease_valid[i] = 1'b0;
							if (o.removed != COUNT_MAX)
								o.removed++;
						end else if (r.now > lease_exp[i]) begin
							// A released lease still overdue is counted again here.
							lease_rel[i]  = 1'b1;
							rel_host[idx] = 1'b1;
							if (o.expired != COUNT_MAX)
								o.expired++;
						end
					end
				end
			end
			default: begin
				if ((r.rip & ~pool_host_mask()) != (pool_base & ~pool_host_mask())) begin
					o.status = ST_NOT_IN_SUBNET;
					return o;
				end
				idx = r.rip & pool_host_mask();
				free_host[idx] = 1'b0;
				rel_host[idx]  = 1'b0;
				rsvd_host[idx] = 1'b1;
			end
		endcase
		return o;
	endfunction

	// Takes the request channel down, waits until the block has answered everything, then
	// writes one register.
	task automatic write_reg(logic idx, logic [31:0] value);
		req_valid <= 1'b0;
		while (owed_rsp_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SUBNET_BASE)
			pool_base = value;
		else
			pool_prefix = value[4:0];
		clear_pool();
	endtask

	// Offers one request, after a random gap, and holds it until it is taken. The valid is
	// only lowered when a gap follows, so it is never dropped and raised in one step.
	task automatic offer_lease(lease_req_t r, bit typed, lease_rsp_t typed_rsp);
		lease_rsp_t p;
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		op            <= r.op;
		mac           <= r.mac;
		lease_seconds <= r.secs;
		now_us        <= r.now;
		reserve_ip    <= r.rip;
		p = predict_lease(r);
		owed_rsp_q.insert(owed_rsp_q.size(), typed ? typed_rsp : p);
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	// Random request. Most traffic uses a handful of clients and a clock that creeps forward,
	// so leases renew, lapse and get released; now and then a field takes any value at all.
	function automatic lease_req_t random_lease();
		lease_req_t  r;
		int unsigned pick;
		pick = $urandom_range(99);
		r.op = (pick < 40) ? OP_ALLOC : (pick < 62) ? OP_RELEASE :
			(pick < 78) ? OP_SWEEP : OP_RESERVE;
		r.mac = ($urandom_range(19) == 0) ? 48'({$urandom, $urandom}) :
			mac_pool[$urandom_range(7)];
		clock_us += 64'($urandom_range(3000000));
		if ($urandom_range(29) == 0)
			r.now = {$urandom, $urandom};
		else
			r.now = clock_us;
		r.secs = ($urandom_range(19) == 0) ? $urandom : $urandom_range(4);
		if ($urandom_range(4) == 0)
			r.rip = $urandom;
		else
			r.rip = (pool_base & ~pool_host_mask()) | ($urandom & pool_host_mask());
		return r;
	endfunction

	// The receiver holds off at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Each response taken is checked against the oldest one owed.
	always @(posedge clk) begin
		lease_rsp_t w;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Response with none owed: status %0d ip %h", status, ip_addr);
			end else begin
				w = owed_rsp_q.pop_front();
				rsp_seen++;
				if (status <= ST_NOT_IN_SUBNET)
					st_seen[status]++;
				if (status !== w.status || ip_addr !== w.ip ||
					expired_count !== w.expired || removed_count !== w.removed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Response %0d: wanted %0d/%h/%0d/%0d, got %0d/%h/%0d/%0d",
							rsp_seen, w.status, w.ip, w.expired, w.removed,
							status, ip_addr, expired_count, removed_count);
				end
			end
		end
	end

	// Counts requests by opcode as the block takes them.
	always @(posedge clk)
		if (arst_n && req_valid && req_ready)
			op_seen[op]++;

	// A hard stop well beyond the slowest correct run.
	initial begin
		#100000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		lease_row_t  rows[$];
		lease_req_t  r;
		lease_rsp_t  none;
		logic [31:0] phase_base [N_PHASES];
		logic [4:0]  phase_pfx  [N_PHASES];
		int unsigned n_items;

		none = '{ST_OK, 32'd0, 9'd0, 9'd0};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_SUBNET_BASE;
		cfg_wdata     = '0;
		req_valid     = 1'b0;
		op            = OP_ALLOC;
		mac           = '0;
		lease_seconds = '0;
		now_us        = '0;
		reserve_ip    = '0;
		tx_idle_pct   = 34;
		rx_idle_pct   = 47;
		mismatches    = 0;
		rsp_seen      = 0;
		clock_us      = '0;
		foreach (op_seen[i])
			op_seen[i] = 0;
		foreach (st_seen[i])
			st_seen[i] = 0;
		pool_base   = '0;
		pool_prefix = PREFIX_RESET;
		clear_pool();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests on the reset pool, base zero and a /24: hosts 1 to 254.
		// The first client takes host 1 and the all-ones client host 2, with an expiry
		// that wraps; a repeat of the first renews host 1.
		rows.insert(rows.size(), '{'{OP_ALLOC, 48'h0, 32'd0, 64'd0, 32'd0}, 1,
			'{ST_OK, 32'd1, 9'd0, 9'd0}});
		rows.insert(rows.size(), '{'{OP_ALLOC, '1, '1, '1, 32'd0}, 1,
			'{ST_OK, 32'd2, 9'd0, 9'd0}});
		rows.insert(rows.size(), '{'{OP_ALLOC, 48'h0, 32'd5, 64'd10, 32'd0}, 1,
			'{ST_OK, 32'd1, 9'd0, 9'd0}});
		rows.insert(rows.size(), '{'{OP_RELEASE, 48'h123456789abc, 32'd0, 64'd20, 32'd0}, 1,
			'{ST_NOT_FOUND, 32'd0, 9'd0, 9'd0}});
		// Release then allocate again: the released host is still marked, so it renews.
		rows.insert(rows.size(), '{'{OP_RELEASE, 48'h0, 32'd0, 64'd30, 32'd0}, 0,
			none});
		rows.insert(rows.size(), '{'{OP_ALLOC, 48'h0, 32'd1, 64'd40, 32'd0}, 0,
			none});
		// Reserving the host under a live lease refuses its renewal.
		rows.insert(rows.size(), '{'{OP_RESERVE, 48'h0, 32'd0, 64'd50, 32'd1}, 0,
			none});
		rows.insert(rows.size(), '{'{OP_ALLOC, 48'h0, 32'd2, 64'd60, 32'd0}, 0,
			none});
		rows.insert(rows.size(), '{'{OP_RESERVE, 48'h0, 32'd0, 64'd70, 32'h100}, 1,
			'{ST_NOT_IN_SUBNET, 32'd0, 9'd0, 9'd0}});
		rows.insert(rows.size(), '{'{OP_RESERVE, 48'h0, 32'd0, 64'd80, '1}, 1,
			'{ST_NOT_IN_SUBNET, 32'd0, 9'd0, 9'd0}});
		rows.insert(rows.size(), '{'{OP_RESERVE, 48'h0, 32'd0, 64'd90, 32'hfe}, 0,
			none});
		rows.insert(rows.size(), '{'{OP_ALLOC, 48'h5a5a5a5a5a5a, 32'd0, 64'd100, 32'd0}, 0,
			none});
		// Sweeps: an overdue lease lapses, and a released one still overdue counts again.
		rows.insert(rows.size(), '{'{OP_SWEEP, 48'h0, 32'd0, 64'd5000000000, 32'd0}, 0,
			none});
		rows.insert(rows.size(),
			'{'{OP_RELEASE, 48'h5a5a5a5a5a5a, 32'd0, 64'd5000000001, 32'd0}, 0, none});
		rows.insert(rows.size(), '{'{OP_SWEEP, 48'h0, 32'd0, 64'd9000000000, 32'd0}, 0,
			none});
		rows.insert(rows.size(), '{'{OP_SWEEP, 48'h0, 32'd0, '1, 32'd0}, 0,
			none});
		rows.insert(rows.size(), '{'{OP_ALLOC, 48'ha5a5a5a5a5a5, 32'd3, 64'd0, 32'd0}, 0,
			none});
		foreach (rows[i])
			offer_lease(rows[i].req, rows[i].typed, rows[i].rsp);

		// Register settings for the random phases; small pools reach exhaustion and the
		// refused renewal of a released lease, a base with host bits set shifts the index.
		phase_base = '{32'h0, 32'hffffffff, $urandom, 32'hc0a80100, $urandom,
			$urandom, 32'h0a000003, $urandom, $urandom};
		phase_pfx  = '{5'd30, 5'd29, 5'd28, 5'd24, 5'd30, 5'd22, 5'd27, 5'd26, 5'd22};
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == 3) begin
				tx_idle_pct = 47;
				rx_idle_pct = 34;
			end else if (ph == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_reg(REG_SUBNET_BASE, phase_base[ph]);
			write_reg(REG_PREFIX_LEN, {27'd0, phase_pfx[ph]});
			foreach (mac_pool[i])
				mac_pool[i] = 48'({$urandom, $urandom});
			mac_pool[0] = '0;
			mac_pool[1] = '1;
			if (ph == N_PHASES - 1) begin
				// Fill every slot of the table from a large pool; the next new client
				// finds the table full, then releases and a sweep tidy up.
				for (int i = 0; i <= LEASE_N; i++) begin
					r = '{OP_ALLOC, 48'h020000000000 + i, 32'd100, clock_us, 32'd0};
					offer_lease(r, 0, none);
				end
				for (int i = 0; i < 20; i++) begin
					r = '{OP_RELEASE, 48'h020000000000 + $urandom_range(LEASE_N), 32'd0,
						clock_us, 32'd0};
					offer_lease(r, 0, none);
				end
				r = '{OP_SWEEP, 48'h0, 32'd0, clock_us + 64'd500000000, 32'd0};
				offer_lease(r, 0, none);
			end else begin
				n_items = 200;
				for (int i = 0; i < n_items; i++)
					offer_lease(random_lease(), 0, none);
			end
		end

		// Let the last request go, then wait for every response owed and a little more.
		@(posedge clk);
		req_valid <= 1'b0;
		while (owed_rsp_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Checked %0d responses: %0d allocate, %0d release, %0d sweep, %0d reserve.",
			rsp_seen, op_seen[OP_ALLOC], op_seen[OP_RELEASE], op_seen[OP_SWEEP],
			op_seen[OP_RESERVE]);
		$display("Status seen: ok %0d, no address %0d, not found %0d, full %0d, outside %0d.",
			st_seen[ST_OK], st_seen[ST_NO_ADDRESS], st_seen[ST_NOT_FOUND],
			st_seen[ST_TABLE_FULL], st_seen[ST_NOT_IN_SUBNET]);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches.", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
src/dla_pkg.sv
src/dhcp_lease_allocator.sv
tb/tb_dhcp_lease_allocator.sv
